// ===== rtl/core/moving_average_filter_defines.svh =====
// ----------------------------------------------------------------------------
// Moving average filter assertion macros
// Shared assertion wrappers for the moving average filter checkers.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_FILTER_DEFINES_SVH
`define MOVING_AVERAGE_FILTER_DEFINES_SVH

// Clocked assertion, quiet while reset is applied.
`define MAVG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Clocked assertion that is also checked while reset is applied.
`define MAVG_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/core/mavg_pkg.sv =====
// ----------------------------------------------------------------------------
// Moving average filter package
// Shared constants for the moving average filter.
// ----------------------------------------------------------------------------
package mavg_pkg;

  // Default store depth and sample width.
  localparam int MaxWindowDef  = 64;
  localparam int SampleBitsDef = 16;

  // Window size register.
  localparam int             CfgW     = 7;
  localparam logic [CfgW-1:0] WsReset = CfgW'(8);

  // Depth of the queue between the front and back parts.
  localparam int QueueDepth = 2;

endpackage

// ===== rtl/core/mavg_ram.sv =====
// ----------------------------------------------------------------------------
// Moving average filter RAM
// Generic memory, one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module mavg_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // A read and a write at the same address return the old contents.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/mavg_fifo.sv =====
// ----------------------------------------------------------------------------
// Moving average filter queue
// Small register queue that decouples the front and back parts.
// ----------------------------------------------------------------------------
module mavg_fifo #(
  parameter int  Depth = 2,
  parameter type T     = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  T     push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output T     pop_data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  T                entry_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = entry_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/mavg_front.sv =====
// ----------------------------------------------------------------------------
// Moving average filter front part
// Accepts samples, keeps the window position and fill count, stores the
// sample and fetches the sample it displaces.
// ----------------------------------------------------------------------------
module mavg_front
  import mavg_pkg::*;
#(
  parameter int MaxWindow  = MaxWindowDef,
  parameter int SampleBits = SampleBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [CfgW-1:0]                     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SampleBits-1:0]        sample_i,
  output logic                                job_valid_o,
  input  logic                                job_ready_i,
  output logic signed [SampleBits-1:0]        job_sample_o,
  output logic signed [SampleBits-1:0]        job_old_o,
  output logic                                job_replace_o,
  output logic [$clog2(MaxWindow + 1)-1:0]    job_count_o
);

  localparam int IdxW = $clog2(MaxWindow);
  localparam int CntW = $clog2(MaxWindow + 1);

  logic [CfgW-1:0]              ws_q;
  logic [IdxW-1:0]              wp_q;
  logic [CntW-1:0]              cnt_q;
  logic [CntW-1:0]              win;
  logic [CntW-1:0]              wp_inc;
  logic                         full;
  logic                         accept;
  logic                         stage_valid_q;
  logic signed [SampleBits-1:0] stage_sample_q;
  logic                         stage_replace_q;
  logic [CntW-1:0]              stage_count_q;
  logic [SampleBits-1:0]        ram_rdata;

  // Effective window: zero acts as one, anything above the store depth as the depth.
  always_comb begin
    if (ws_q == '0) begin
      win = CntW'(1);
    end else if (ws_q > MaxWindow) begin
      win = CntW'(MaxWindow);
    end else begin
      win = CntW'(ws_q);
    end
  end

  assign full       = (cnt_q == win);
  assign wp_inc     = CntW'(wp_q) + CntW'(1);
  assign in_ready_o = !stage_valid_q;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q          <= WsReset;
      wp_q          <= '0;
      cnt_q         <= '0;
      stage_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ws_q  <= cfg_wdata_i;
        wp_q  <= '0;
        cnt_q <= '0;
      end else if (accept) begin
        wp_q <= (wp_inc == win) ? '0 : IdxW'(wp_inc);
        if (!full) begin
          cnt_q <= cnt_q + CntW'(1);
        end
      end
      if (accept) begin
        stage_valid_q <= 1'b1;
      end else if (job_ready_i) begin
        stage_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_sample_q  <= sample_i;
      stage_replace_q <= full;
      stage_count_q   <= full ? cnt_q : cnt_q + CntW'(1);
    end
  end

  // The read returns the displaced sample; the write stores the new one.
  mavg_ram #(
    .Width (SampleBits),
    .Depth (MaxWindow)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wp_q),
    .wdata_i (sample_i),
    .re_i    (accept),
    .raddr_i (wp_q),
    .rdata_o (ram_rdata)
  );

  assign job_valid_o   = stage_valid_q;
  assign job_sample_o  = stage_sample_q;
  assign job_old_o     = ram_rdata;
  assign job_replace_o = stage_replace_q;
  assign job_count_o   = stage_count_q;

endmodule

// ===== rtl/core/mavg_back.sv =====
// ----------------------------------------------------------------------------
// Moving average filter back part
// Updates the running window sum and divides it by the fill count with a
// bit-serial restoring divider.
// ----------------------------------------------------------------------------
module mavg_back
  import mavg_pkg::*;
#(
  parameter int MaxWindow  = MaxWindowDef,
  parameter int SampleBits = SampleBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                clear_i,
  input  logic                                job_valid_i,
  output logic                                job_ready_o,
  input  logic signed [SampleBits-1:0]        job_sample_i,
  input  logic signed [SampleBits-1:0]        job_old_i,
  input  logic                                job_replace_i,
  input  logic [$clog2(MaxWindow + 1)-1:0]    job_count_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [SampleBits-1:0]        average_o,
  output logic [$clog2(MaxWindow + 1)-1:0]    fill_count_o
);

  localparam int CntW  = $clog2(MaxWindow + 1);
  localparam int SumW  = SampleBits + $clog2(MaxWindow) + 1;
  localparam int StepW = $clog2(SumW);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StDone = 3'b100
  } back_state_e;

  back_state_e              state_q, state_d;
  logic signed [SumW-1:0]   sum_q;
  logic signed [SumW-1:0]   sum_new;
  logic [SumW-1:0]          sum_mag;
  logic [SumW-1:0]          dvd_q;
  logic [CntW-1:0]          rem_q;
  logic [CntW-1:0]          div_q;
  logic [StepW-1:0]         step_q;
  logic                     neg_q;
  logic [CntW:0]            trial;
  logic                     fits;
  logic [SumW-1:0]          quo;
  logic                     pop;
  logic                     load_out;
  logic                     out_valid_q;
  logic signed [SampleBits-1:0] avg_q;
  logic [CntW-1:0]          fill_q;

  assign job_ready_o = (state_q == StIdle);
  assign pop         = job_valid_i && job_ready_o;
  assign load_out    = (state_q == StDone) && (!out_valid_q || out_ready_i);

  assign sum_new = sum_q + SumW'(job_sample_i)
                 - (job_replace_i ? SumW'(job_old_i) : SumW'(0));
  assign sum_mag = sum_new[SumW-1] ? SumW'(-sum_new) : SumW'(sum_new);

  assign trial = {rem_q, dvd_q[SumW-1]};
  assign fits  = (trial >= {1'b0, div_q});
  assign quo   = neg_q ? SumW'(-dvd_q) : dvd_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (pop) begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (step_q == StepW'(SumW - 1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clear_i) begin
        sum_q <= '0;
      end else if (pop) begin
        sum_q <= sum_new;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      dvd_q  <= sum_mag;
      rem_q  <= '0;
      div_q  <= job_count_i;
      step_q <= '0;
      neg_q  <= sum_new[SumW-1];
      fill_q <= job_count_i;
    end else if (state_q == StDiv) begin
      dvd_q  <= {dvd_q[SumW-2:0], fits};
      rem_q  <= fits ? CntW'(trial - {1'b0, div_q}) : CntW'(trial);
      step_q <= step_q + StepW'(1);
    end
    if (load_out) begin
      avg_q        <= SampleBits'(quo);
      fill_count_o <= fill_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign average_o   = avg_q;

endmodule

// ===== rtl/core/moving_average_filter.sv =====
// ----------------------------------------------------------------------------
// Moving average filter
// Simple moving average of signed samples over a programmable window.
// ----------------------------------------------------------------------------
// Each sample transfer yields one result transfer: the mean of the samples in
// the window, truncated toward zero, and the number of samples it covers. The
// window size register (0 acts as 1, values above MaxWindow act as MaxWindow)
// restarts filling whenever it is written, even with its current value; write
// it only while no sample is in flight. The back part takes one sample at a
// time; the queue holds the next until the bit-serial divider, which retires
// one quotient bit per cycle over the SumW-bit running sum (SumW = SampleBits
// + clog2(MaxWindow) + 1), has finished the previous one and its result has
// moved to the output register. A result passes through the front part's
// store access, the queue and the back part, in that order.
// ----------------------------------------------------------------------------
module moving_average_filter
  import mavg_pkg::*;
#(
  parameter int MaxWindow  = MaxWindowDef,
  parameter int SampleBits = SampleBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [CfgW-1:0]                  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [SampleBits-1:0]     sample_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [SampleBits-1:0]     average_o,
  output logic [$clog2(MaxWindow + 1)-1:0] fill_count_o
);

  localparam int CntW = $clog2(MaxWindow + 1);

  // One queued job: the new sample, the sample it displaces (valid only when
  // the window is already full) and the fill count after this sample.
  typedef struct packed {
    logic signed [SampleBits-1:0] sample;
    logic signed [SampleBits-1:0] old;
    logic                         replace;
    logic [CntW-1:0]              count;
  } job_t;

  job_t front_job;
  job_t back_job;
  logic front_valid, front_ready;
  logic back_valid, back_ready;

  // The front part writes the sample into the window store and reads the
  // entry it overwrites in the same cycle, then offers the job to the queue.
  mavg_front #(
    .MaxWindow  (MaxWindow),
    .SampleBits (SampleBits)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_i      (sample_i),
    .job_valid_o   (front_valid),
    .job_ready_i   (front_ready),
    .job_sample_o  (front_job.sample),
    .job_old_o     (front_job.old),
    .job_replace_o (front_job.replace),
    .job_count_o   (front_job.count)
  );

  // The queue lets the front part take the next sample while the divider is
  // still busy with the previous one.
  mavg_fifo #(
    .Depth (QueueDepth),
    .T     (job_t)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_job),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_job)
  );

  // The back part keeps the running window sum: a filling window adds the new
  // sample, a full window also subtracts the displaced one. A register write
  // clears the sum together with the front part's position and count.
  mavg_back #(
    .MaxWindow  (MaxWindow),
    .SampleBits (SampleBits)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       (cfg_we_i),
    .job_valid_i   (back_valid),
    .job_ready_o   (back_ready),
    .job_sample_i  (back_job.sample),
    .job_old_i     (back_job.old),
    .job_replace_i (back_job.replace),
    .job_count_i   (back_job.count),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .average_o     (average_o),
    .fill_count_o  (fill_count_o)
  );

endmodule

// ===== rtl/core/mavg_checker.sv =====
// ----------------------------------------------------------------------------
// Moving average filter checker
// Port-level assertions, bound to the moving average filter.
// ----------------------------------------------------------------------------
`include "moving_average_filter_defines.svh"

module mavg_checker
  import mavg_pkg::*;
#(
  parameter int MaxWindow  = MaxWindowDef,
  parameter int SampleBits = SampleBitsDef
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             cfg_we_i,
  input logic [CfgW-1:0]                  cfg_wdata_i,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic signed [SampleBits-1:0]     sample_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [SampleBits-1:0]     average_o,
  input logic [$clog2(MaxWindow + 1)-1:0] fill_count_o
);

  // A stalled result must hold until it is taken.
  `MAVG_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(average_o) && $stable(fill_count_o), "result changed while stalled")

  // Every result covers at least one sample and no more than the store holds.
  `MAVG_ASSERT(a_fill_range, out_valid_o |-> fill_count_o != '0 && fill_count_o <= MaxWindow, "fill count out of range")

  // The front part holds one sample at a time, so it stalls after each transfer.
  `MAVG_ASSERT(a_front_busy, in_valid_i && in_ready_o |=> !in_ready_o, "second sample taken back to back")

  // Reset leaves no result pending.
  `MAVG_ASSERT_RST(a_reset_idle, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind moving_average_filter mavg_checker #(
  .MaxWindow  (MaxWindow),
  .SampleBits (SampleBits)
) u_mavg_checker (.*);
